// ===== design/srcsort_pkg.sv =====
// shared types and constants for the segmented row/column sorter
// no dependencies; imported by every module of the block
package srcsort_pkg;

	localparam int MAX_SEGMENT_DEF = 32;
	localparam int INDEX_BITS_DEF  = 20;
	localparam int VALUE_BITS      = 64;
	localparam int QUEUE_DEPTH     = 2;

	// classification of one word, made by the front part
	typedef struct packed {
		logic close_seg;  // row went up: emit the open segment before inserting
		logic fin;        // last word of the array: emit after inserting
	} cmd_flags_t;

	localparam int FLAGS_BITS = $bits(cmd_flags_t);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FLUSH,
		S_INSERT,
		S_DRAIN
	} back_state_t;

endpackage

// ===== design/srcsort_front.sv =====
// front part: accepts input words, tracks the previous row, classifies each word
// depends on srcsort_pkg; feeds srcsort_fifo
module srcsort_front import srcsort_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  entry_valid,
	output logic                  entry_stall,
	input  logic [INDEX_BITS-1:0] row_index,
	input  logic [INDEX_BITS-1:0] column_index,
	input  logic [VALUE_BITS-1:0] value_bits,
	input  logic                  final_entry,
	input  logic                  queue_full,
	output logic                  push,
	output logic [FLAGS_BITS+INDEX_BITS+VALUE_BITS-1:0] push_data
);

	logic [INDEX_BITS-1:0] prev_row_q;
	logic                  have_prev_q;
	cmd_flags_t            flags;

	assign entry_stall     = queue_full;
	assign push            = entry_valid && !queue_full;
	assign flags.close_seg = have_prev_q && (row_index > prev_row_q);
	assign flags.fin       = final_entry;
	assign push_data       = {flags, column_index, value_bits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_row_q  <= '0;
			have_prev_q <= 1'b0;
		end else if (push) begin
			// final word returns to the reset state so a new array starts fresh
			prev_row_q  <= final_entry ? '0 : row_index;
			have_prev_q <= !final_entry;
		end
	end

endmodule

// ===== design/srcsort_fifo.sv =====
// short command queue between the front and back parts
// depends on srcsort_pkg for the default depth
module srcsort_fifo import srcsort_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty,
	output logic             full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/srcsort_back.sv =====
// back part: sorted insertion buffer, segment emission and the output register
// depends on srcsort_pkg; reads commands from srcsort_fifo
module srcsort_back import srcsort_pkg::*; #(
	parameter int MAX_SEGMENT = MAX_SEGMENT_DEF,
	parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [FLAGS_BITS+INDEX_BITS+VALUE_BITS-1:0] head_data,
	input  logic                  queue_empty,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [INDEX_BITS-1:0] sorted_column,
	output logic [VALUE_BITS-1:0] sorted_value,
	output logic                  segment_end,
	output logic                  overflow,
	output logic                  last_of_run
);

	localparam int CW = $clog2(MAX_SEGMENT + 1);

	cmd_flags_t            head_flags;
	logic [INDEX_BITS-1:0] head_col;
	logic [VALUE_BITS-1:0] head_val;

	assign {head_flags, head_col, head_val} = head_data;

	back_state_t           state_q;
	back_state_t           state_nxt;
	logic [CW-1:0]         count_q;
	logic                  ovf_q;
	logic [INDEX_BITS-1:0] cmd_col_q;
	logic [VALUE_BITS-1:0] cmd_val_q;
	logic                  cmd_fin_q;

	logic [INDEX_BITS-1:0] col_buf_q [MAX_SEGMENT];
	logic [VALUE_BITS-1:0] val_buf_q [MAX_SEGMENT];

	logic                  result_valid_q;
	logic [INDEX_BITS-1:0] out_col_q;
	logic [VALUE_BITS-1:0] out_val_q;
	logic                  out_end_q;
	logic                  out_ovf_q;
	logic                  out_lor_q;

	logic                  slot_free;
	logic                  emit;
	logic                  ins_en;
	logic                  buf_full;
	logic                  last_entry;
	logic [INDEX_BITS-1:0] ins_col;
	logic [VALUE_BITS-1:0] ins_val;
	logic [MAX_SEGMENT-1:0] gt;
	logic [MAX_SEGMENT-1:0] gt_prev;

	assign slot_free  = !result_valid_q || !result_stall;
	assign buf_full   = (count_q == CW'(MAX_SEGMENT));
	assign last_entry = (count_q == CW'(1));
	assign ins_col    = (state_q == S_INSERT) ? cmd_col_q : head_col;
	assign ins_val    = (state_q == S_INSERT) ? cmd_val_q : head_val;

	// entries with a strictly larger column move up one place
	always_comb begin
		for (int i = 0; i < MAX_SEGMENT; i++) begin
			gt[i] = (CW'(i) < count_q) && (col_buf_q[i] > ins_col);
		end
	end
	assign gt_prev = {gt[MAX_SEGMENT-2:0], 1'b0};

	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		ins_en    = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (!queue_empty) begin
					pop = 1'b1;
					if (head_flags.close_seg) begin
						state_nxt = S_FLUSH;
					end else begin
						ins_en    = 1'b1;
						state_nxt = head_flags.fin ? S_DRAIN : S_IDLE;
					end
				end
			end
			S_FLUSH: begin
				if (slot_free) begin
					emit = 1'b1;
					if (last_entry) begin
						state_nxt = S_INSERT;
					end
				end
			end
			S_INSERT: begin
				ins_en    = 1'b1;
				state_nxt = cmd_fin_q ? S_DRAIN : S_IDLE;
			end
			S_DRAIN: begin
				if (slot_free) begin
					emit = 1'b1;
					if (last_entry) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit) begin
				count_q <= count_q - CW'(1);
				if (last_entry) begin
					ovf_q <= 1'b0;
				end
			end else if (ins_en) begin
				if (buf_full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_col_q <= head_col;
			cmd_val_q <= head_val;
			cmd_fin_q <= head_flags.fin;
		end
	end

	for (genvar g = 0; g < MAX_SEGMENT; g++) begin : g_entry
		if (g == MAX_SEGMENT - 1) begin : g_top
			always_ff @(posedge clk) begin
				if (ins_en && !buf_full) begin
					if (gt_prev[g]) begin
						col_buf_q[g] <= col_buf_q[g-1];
						val_buf_q[g] <= val_buf_q[g-1];
					end else if (gt[g] || count_q == CW'(g)) begin
						col_buf_q[g] <= ins_col;
						val_buf_q[g] <= ins_val;
					end
				end
			end
		end else if (g == 0) begin : g_bottom
			always_ff @(posedge clk) begin
				if (emit) begin
					col_buf_q[g] <= col_buf_q[g+1];
					val_buf_q[g] <= val_buf_q[g+1];
				end else if (ins_en && !buf_full) begin
					if (gt[g] || count_q == CW'(g)) begin
						col_buf_q[g] <= ins_col;
						val_buf_q[g] <= ins_val;
					end
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (emit) begin
					col_buf_q[g] <= col_buf_q[g+1];
					val_buf_q[g] <= val_buf_q[g+1];
				end else if (ins_en && !buf_full) begin
					if (gt_prev[g]) begin
						col_buf_q[g] <= col_buf_q[g-1];
						val_buf_q[g] <= val_buf_q[g-1];
					end else if (gt[g] || count_q == CW'(g)) begin
						col_buf_q[g] <= ins_col;
						val_buf_q[g] <= ins_val;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_col_q <= col_buf_q[0];
			out_val_q <= val_buf_q[0];
			out_end_q <= last_entry;
			out_ovf_q <= ovf_q;
			// an item that both closes and ends the array finishes on the drain
			out_lor_q <= last_entry && ((state_q == S_DRAIN) || !cmd_fin_q);
		end
	end

	assign result_valid  = result_valid_q;
	assign sorted_column = out_col_q;
	assign sorted_value  = out_val_q;
	assign segment_end   = out_end_q;
	assign overflow      = out_ovf_q;
	assign last_of_run   = out_lor_q;

endmodule

// ===== design/sparse_row_column_sorter_top.sv =====
// top level of the segmented row/column sorter for sparse-matrix entries
// depends on srcsort_pkg, srcsort_front, srcsort_fifo, srcsort_back
//
// channel   direction  handshake                   payload
// entry     in         entry_valid / entry_stall   row_index column_index value_bits final_entry
// result    out        result_valid / result_stall sorted_column sorted_value segment_end
//                                                  overflow last_of_run
//
// a word that closes no segment is inserted straight from the queue head (parallel sorted insert)
// a word whose row goes up is decoded, the open segment is emitted, then the word is inserted
// a final word then has the segment it ends emitted; emits go one per cycle while result_stall does not hold them
// the front accepts a word every cycle while the two-entry command queue has room
// arst_n clears the queue, the segment count and the row tracking; buffer data is unreset
// result_stall holds the output register; the back part waits, the front keeps queueing
module sparse_row_column_sorter_top import srcsort_pkg::*; #(
	parameter int MAX_SEGMENT = MAX_SEGMENT_DEF,
	parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  entry_valid,
	output logic                  entry_stall,
	input  logic [INDEX_BITS-1:0] row_index,
	input  logic [INDEX_BITS-1:0] column_index,
	input  logic [VALUE_BITS-1:0] value_bits,
	input  logic                  final_entry,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [INDEX_BITS-1:0] sorted_column,
	output logic [VALUE_BITS-1:0] sorted_value,
	output logic                  segment_end,
	output logic                  overflow,
	output logic                  last_of_run
);

	localparam int CMD_BITS = FLAGS_BITS + INDEX_BITS + VALUE_BITS;

	// command queue wiring
	logic                push;
	logic [CMD_BITS-1:0] push_data;
	logic                pop;
	logic [CMD_BITS-1:0] head_data;
	logic                queue_empty;
	logic                queue_full;

	// front: previous-row tracking and segment-close detection
	srcsort_front #(
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_valid  (entry_valid),
		.entry_stall  (entry_stall),
		.row_index    (row_index),
		.column_index (column_index),
		.value_bits   (value_bits),
		.final_entry  (final_entry),
		.queue_full   (queue_full),
		.push         (push),
		.push_data    (push_data)
	);

	// decouples word acceptance from emission stalls
	srcsort_fifo #(
		.WIDTH (CMD_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.empty     (queue_empty),
		.full      (queue_full)
	);

	// back: insertion buffer kept in column order, shifted out on emit
	srcsort_back #(
		.MAX_SEGMENT (MAX_SEGMENT),
		.INDEX_BITS  (INDEX_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_data     (head_data),
		.queue_empty   (queue_empty),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.sorted_column (sorted_column),
		.sorted_value  (sorted_value),
		.segment_end   (segment_end),
		.overflow      (overflow),
		.last_of_run   (last_of_run)
	);

endmodule
